// File: rtl/core/dnsd_pkg.sv
// Package for the DNS name decompressor: operation and error codes, walk
// states, the result record and default sizes. No dependencies.
package dnsd_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 512;

  // Walk position width: a 14-bit pointer target or the byte past the end.
  localparam int PTR_W = 15;
  localparam int END_W = 10;
  localparam int LABEL_W = 6;
  localparam int JUMP_W = 4;

  localparam logic [JUMP_W-1:0] DEFAULT_MAX_JUMPS = 4'd5;
  localparam logic [7:0] PTR_MARK = 8'hc0;
  localparam logic [7:0] DOT_CHAR = 8'h2e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_JUMPS = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CHAR = 2'd1,
    S_HEAD = 2'd2,
    S_PTR  = 2'd3
  } walk_state_t;

  typedef struct packed {
    logic [7:0]       name_char;
    logic             char_valid;
    logic             name_done;
    err_t             error_code;
    logic [END_W-1:0] end_position;
  } result_t;

endpackage

// File: rtl/core/dnsd_packet_ram.sv
// Packet byte store for the DNS name decompressor: one write port and one
// read port with registered read data. Uses dnsd_pkg for the default depth.
module dnsd_packet_ram #(
  parameter int BUFFER_BYTES = dnsd_pkg::DEFAULT_BUFFER_BYTES,
  parameter int ADDR_W = $clog2(dnsd_pkg::DEFAULT_BUFFER_BYTES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/dns_name_decompressor.sv
// Top level of the DNS name decompressor: command port, walk sequencer and
// result register. Depends on dnsd_pkg and dnsd_packet_ram.
//
// The block holds one DNS message of BUFFER_BYTES bytes and walks a domain
// name in it one character per fetch. A transaction is accepted at a clock
// edge where start is high and busy is low; every transaction produces exactly
// one result, shown for a single cycle with out_valid high, and the receiver
// must take it then because there is no way to hold results off. Writes,
// starts, unknown operations and fetches while no walk is active return their
// all-zero result in the cycle after acceptance and never raise busy, so such
// transactions can be issued every cycle. A fetch holds busy high while it
// reads the packet memory, one read after another through its single read
// port: a character inside a label needs one read, the dot between labels
// one (the length byte), the first character of a label two (length byte,
// then character), and each compression pointer followed adds two (its second
// byte and the byte at its target). Range errors that can be seen from the
// walk position alone are reported without a memory read.
// The packet memory has no reset and no clearing pass; reading bytes that
// were never written gives undefined characters. The jump limit register
// (cfg_write_enable, cfg_write_data) resets to five and should be written
// only while no transaction is in flight.
module dns_name_decompressor #(
  parameter int BUFFER_BYTES = dnsd_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [8:0] in_address,
  input  logic [7:0] in_write_data,

  input  logic       cfg_write_enable,
  input  logic [3:0] cfg_write_data,

  output logic       out_valid,
  output logic [7:0] out_name_char,
  output logic       out_char_valid,
  output logic       out_name_done,
  output logic [1:0] out_error_code,
  output logic [9:0] out_end_position
);

  import dnsd_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam logic [PTR_W-1:0] BUF_L = PTR_W'(BUFFER_BYTES);

  // Sequencer and walk state.
  walk_state_t         state_r, state_nxt;
  logic [PTR_W-1:0]    walk_ptr_r, walk_ptr_nxt;
  logic [LABEL_W-1:0]  label_rem_r, label_rem_nxt;
  logic [JUMP_W-1:0]   jump_cnt_r, jump_cnt_nxt;
  logic                has_jumped_r, has_jumped_nxt;
  logic [END_W-1:0]    saved_end_r, saved_end_nxt;
  logic                dot_pending_r, dot_pending_nxt;
  logic                walk_active_r, walk_active_nxt;
  logic [5:0]          ptr_hi_r, ptr_hi_nxt;
  logic [JUMP_W-1:0]   max_jumps_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  result_t             result_r, result_nxt;

  // Packet memory ports.
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          rd_data;

  // Decode shared by the next-state and datapath logic.
  logic                accept;
  op_t                 op;
  logic [PTR_W-1:0]    addr_ext;
  logic [PTR_W-1:0]    ptr_plus1;
  logic [PTR_W-1:0]    label_end;
  logic [PTR_W-1:0]    jump_target;
  logic                walk_in_range;
  logic                head_is_ptr;
  logic                head_reserved;
  logic                head_is_term;
  logic                ptr_second_ok;
  logic                jumps_left;
  logic                label_fits;
  logic                target_ok;

  assign accept        = start && !busy;
  assign op            = op_t'(in_operation);
  assign addr_ext      = PTR_W'(in_address);
  assign ptr_plus1     = walk_ptr_r + PTR_W'(1);
  assign label_end     = ptr_plus1 + PTR_W'(rd_data);
  assign jump_target   = PTR_W'({ptr_hi_r, rd_data});
  assign walk_in_range = walk_ptr_r < BUF_L;
  assign head_is_ptr   = (rd_data & PTR_MARK) == PTR_MARK;
  assign head_reserved = !head_is_ptr && ((rd_data & PTR_MARK) != 8'h00);
  assign head_is_term  = rd_data == 8'h00;
  assign ptr_second_ok = ptr_plus1 < BUF_L;
  assign jumps_left    = jump_cnt_r < max_jumps_r;
  assign label_fits    = label_end <= BUF_L;
  assign target_ok     = jump_target < BUF_L;

  dnsd_packet_ram #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_write_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && op == OP_FETCH && walk_active_r) begin
          if (label_rem_r != '0) begin
            state_nxt = S_CHAR;
          end else if (walk_in_range) begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_CHAR: begin
        state_nxt = S_IDLE;
      end
      S_HEAD: begin
        state_nxt = S_IDLE;
        if (head_is_ptr) begin
          if (ptr_second_ok && jumps_left) begin
            state_nxt = S_PTR;
          end
        end else if (!head_reserved && !head_is_term && label_fits && !dot_pending_r) begin
          state_nxt = S_CHAR;
        end
      end
      S_PTR: begin
        state_nxt = target_ok ? S_HEAD : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Walk datapath, memory requests and result.
  always_comb begin
    walk_ptr_nxt    = walk_ptr_r;
    label_rem_nxt   = label_rem_r;
    jump_cnt_nxt    = jump_cnt_r;
    has_jumped_nxt  = has_jumped_r;
    saved_end_nxt   = saved_end_r;
    dot_pending_nxt = dot_pending_r;
    walk_active_nxt = walk_active_r;
    ptr_hi_nxt      = ptr_hi_r;
    out_valid_nxt   = 1'b0;
    result_nxt      = '0;
    wr_en           = 1'b0;
    wr_addr         = addr_ext[ADDR_W-1:0];
    rd_en           = 1'b0;
    rd_addr         = walk_ptr_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (op)
            OP_WRITE: begin
              wr_en = addr_ext < BUF_L;
            end
            OP_START: begin
              walk_ptr_nxt    = addr_ext;
              label_rem_nxt   = '0;
              jump_cnt_nxt    = '0;
              has_jumped_nxt  = 1'b0;
              saved_end_nxt   = '0;
              dot_pending_nxt = 1'b0;
              walk_active_nxt = 1'b1;
            end
            OP_FETCH: begin
              if (walk_active_r) begin
                if (label_rem_r != '0 || walk_in_range) begin
                  // The result comes after the memory read.
                  rd_en         = 1'b1;
                  out_valid_nxt = 1'b0;
                end else begin
                  walk_active_nxt       = 1'b0;
                  result_nxt.name_done  = 1'b1;
                  result_nxt.error_code = ERR_RANGE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CHAR: begin
        out_valid_nxt         = 1'b1;
        result_nxt.name_char  = walk_in_range ? rd_data : 8'h00;
        result_nxt.char_valid = 1'b1;
        walk_ptr_nxt          = ptr_plus1;
        label_rem_nxt         = label_rem_r - LABEL_W'(1);
        if (label_rem_r == LABEL_W'(1)) begin
          dot_pending_nxt = 1'b1;
        end
      end

      S_HEAD: begin
        if (head_is_ptr) begin
          if (!ptr_second_ok) begin
            out_valid_nxt         = 1'b1;
            walk_active_nxt       = 1'b0;
            result_nxt.name_done  = 1'b1;
            result_nxt.error_code = ERR_RANGE;
          end else begin
            // The end position is fixed by the first pointer of the name.
            if (!has_jumped_r) begin
              saved_end_nxt = END_W'(walk_ptr_r + PTR_W'(2));
            end
            has_jumped_nxt = 1'b1;
            if (!jumps_left) begin
              out_valid_nxt         = 1'b1;
              walk_active_nxt       = 1'b0;
              result_nxt.name_done  = 1'b1;
              result_nxt.error_code = ERR_JUMPS;
            end else begin
              ptr_hi_nxt = rd_data[5:0];
              rd_en      = 1'b1;
              rd_addr    = ptr_plus1[ADDR_W-1:0];
            end
          end
        end else if (head_reserved) begin
          out_valid_nxt         = 1'b1;
          walk_active_nxt       = 1'b0;
          result_nxt.name_done  = 1'b1;
          result_nxt.error_code = ERR_RANGE;
        end else if (head_is_term) begin
          out_valid_nxt           = 1'b1;
          walk_active_nxt         = 1'b0;
          result_nxt.name_done    = 1'b1;
          result_nxt.end_position = has_jumped_r ? saved_end_r : END_W'(ptr_plus1);
        end else if (!label_fits) begin
          out_valid_nxt         = 1'b1;
          walk_active_nxt       = 1'b0;
          result_nxt.name_done  = 1'b1;
          result_nxt.error_code = ERR_RANGE;
        end else begin
          walk_ptr_nxt  = ptr_plus1;
          label_rem_nxt = rd_data[LABEL_W-1:0];
          if (dot_pending_r) begin
            out_valid_nxt         = 1'b1;
            dot_pending_nxt       = 1'b0;
            result_nxt.name_char  = DOT_CHAR;
            result_nxt.char_valid = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_plus1[ADDR_W-1:0];
          end
        end
      end

      S_PTR: begin
        jump_cnt_nxt = jump_cnt_r + JUMP_W'(1);
        walk_ptr_nxt = jump_target;
        if (target_ok) begin
          rd_en   = 1'b1;
          rd_addr = jump_target[ADDR_W-1:0];
        end else begin
          out_valid_nxt         = 1'b1;
          walk_active_nxt       = 1'b0;
          result_nxt.name_done  = 1'b1;
          result_nxt.error_code = ERR_RANGE;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      walk_ptr_r    <= '0;
      label_rem_r   <= '0;
      jump_cnt_r    <= '0;
      has_jumped_r  <= 1'b0;
      saved_end_r   <= '0;
      dot_pending_r <= 1'b0;
      walk_active_r <= 1'b0;
      max_jumps_r   <= DEFAULT_MAX_JUMPS;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      walk_ptr_r    <= walk_ptr_nxt;
      label_rem_r   <= label_rem_nxt;
      jump_cnt_r    <= jump_cnt_nxt;
      has_jumped_r  <= has_jumped_nxt;
      saved_end_r   <= saved_end_nxt;
      dot_pending_r <= dot_pending_nxt;
      walk_active_r <= walk_active_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_write_enable) begin
        max_jumps_r <= cfg_write_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    ptr_hi_r <= ptr_hi_nxt;
    result_r <= result_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_name_char    = result_r.name_char;
  assign out_char_valid   = result_r.char_valid;
  assign out_name_done    = result_r.name_done;
  assign out_error_code   = result_r.error_code;
  assign out_end_position = result_r.end_position;

  // An error always ends the name.
  a_error_ends_name: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> out_name_done)
    else $error("error result without name_done");

  // Writes, starts and unknown operations answer in the next cycle with an empty result.
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_FETCH) |=>
      (out_valid && !out_char_valid && !out_name_done))
    else $error("write or start result missing or not empty");

  // A finished name leaves the walk idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_name_done) |-> !walk_active_r)
    else $error("walk still active after name_done");

  // Label bytes are only pending inside an active walk.
  a_label_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (label_rem_r != '0) |-> walk_active_r)
    else $error("label bytes pending while no walk is active");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dns_name_decompressor: fills the packet memory,
// walks names through labels, pointers and error cases under several jump
// limits, and checks every result. Depends on dnsd_pkg and the block's RTL.
module tb_top;
  import dnsd_pkg::*;

  localparam int BUF_BYTES = DEFAULT_BUFFER_BYTES;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [8:0] addr;
    logic [7:0] data;
  } dns_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_operation = OP_WRITE;
  logic [8:0] in_address = '0;
  logic [7:0] in_write_data = '0;
  logic       cfg_write_enable = 1'b0;
  logic [3:0] cfg_write_data = '0;
  logic       out_valid;
  logic [7:0] out_name_char;
  logic       out_char_valid;
  logic       out_name_done;
  logic [1:0] out_error_code;
  logic [9:0] out_end_position;

  dns_name_decompressor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .out_valid        (out_valid),
    .out_name_char    (out_name_char),
    .out_char_valid   (out_char_valid),
    .out_name_done    (out_name_done),
    .out_error_code   (out_error_code),
    .out_end_position (out_end_position)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Commands waiting for the driver, and the results predicted for every
  // transaction the block has taken but not yet answered.
  dns_cmd_t cmd_q[$];
  result_t  name_results_q[$];
  int       name_starts[$];
  int       pushed_count = 0;
  int       accepted_count = 0;
  int       fail_count = 0;
  int       n_chars = 0;
  int       n_names = 0;
  int       n_range_err = 0;
  int       n_jump_err = 0;

  // Predictor state: a private copy of the packet and of the name walk.
  logic [7:0]  pkt_mem [0:BUF_BYTES-1];
  int unsigned walk_pos = 0;
  int unsigned label_left = 0;
  int unsigned jumps_taken = 0;
  bit          followed_ptr = 1'b0;
  int unsigned resume_pos = 0;
  bit          dot_due = 1'b0;
  bit          walking = 1'b0;
  logic [3:0]  jump_limit = DEFAULT_MAX_JUMPS;

  // Ends the walk with an error result.
  function automatic result_t halt_walk(input err_t code);
    result_t r;
    r = '0;
    walking = 1'b0;
    r.name_done = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  // Emits the next byte of the current label.
  function automatic result_t take_label_char();
    result_t r;
    r = '0;
    r.name_char = pkt_mem[walk_pos];
    r.char_valid = 1'b1;
    walk_pos++;
    label_left--;
    if (label_left == 0) dot_due = 1'b1;
    return r;
  endfunction

  // One fetch: follows pointers until a character, the terminator or an error.
  function automatic result_t next_name_char();
    result_t     r;
    int unsigned p;
    logic [7:0]  b;
    r = '0;
    if (!walking) return r;
    if (label_left != 0) return take_label_char();
    while (1'b1) begin
      p = walk_pos;
      if (p >= BUF_BYTES) return halt_walk(ERR_RANGE);
      b = pkt_mem[p];
      if ((b & PTR_MARK) == PTR_MARK) begin
        if (p + 1 >= BUF_BYTES) return halt_walk(ERR_RANGE);
        // The end position is fixed by the first pointer only.
        if (!followed_ptr) resume_pos = p + 2;
        followed_ptr = 1'b1;
        if (jumps_taken >= jump_limit) return halt_walk(ERR_JUMPS);
        jumps_taken++;
        walk_pos = 32'({b[5:0], pkt_mem[p + 1]});
      end else if ((b & PTR_MARK) != 8'h00) begin
        return halt_walk(ERR_RANGE);
      end else if (b == 8'h00) begin
        walking = 1'b0;
        r.name_done = 1'b1;
        r.end_position = followed_ptr ? END_W'(resume_pos) : END_W'(p + 1);
        return r;
      end else begin
        if (p + 1 + b > BUF_BYTES) return halt_walk(ERR_RANGE);
        walk_pos = p + 1;
        label_left = 32'(b);
        if (dot_due) begin
          dot_due = 1'b0;
          r.name_char = DOT_CHAR;
          r.char_valid = 1'b1;
          return r;
        end
        return take_label_char();
      end
    end
    return r;
  endfunction

  function automatic result_t decode_cmd(input dns_cmd_t c);
    result_t r;
    r = '0;
    case (c.op)
      OP_WRITE: begin
        pkt_mem[c.addr] = c.data;
      end
      OP_START: begin
        walk_pos = 32'(c.addr);
        label_left = 0;
        jumps_taken = 0;
        followed_ptr = 1'b0;
        resume_pos = 0;
        dot_due = 1'b0;
        walking = 1'b1;
      end
      OP_FETCH: begin
        r = next_name_char();
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  dns_cmd_t cur_cmd;
  int       gap_left = 0;
  int       burst_left = 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 24);
    end else begin
      if (cfg_write_enable) jump_limit = cfg_write_data;
      if (start && !busy) begin
        name_results_q.push_back(decode_cmd(cur_cmd));
        accepted_count++;
      end
      // Hold the transaction while the block is busy with the previous one.
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          start <= 1'b1;
          in_operation <= cur_cmd.op;
          in_address <= cur_cmd.addr;
          in_write_data <= cur_cmd.data;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want,
             n_chars + n_names + n_range_err + n_jump_err);
  endtask

  // Monitor: every strobed result is compared with the oldest prediction.
  result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (name_results_q.size() == 0) begin
        flag_mismatch("result with no transaction pending", out_name_char, 0);
      end else begin
        want = name_results_q.pop_front();
        if (out_name_char !== want.name_char)
          flag_mismatch("name_char", out_name_char, want.name_char);
        if (out_char_valid !== want.char_valid)
          flag_mismatch("char_valid", out_char_valid, want.char_valid);
        if (out_name_done !== want.name_done)
          flag_mismatch("name_done", out_name_done, want.name_done);
        if (out_error_code !== want.error_code)
          flag_mismatch("error_code", out_error_code, want.error_code);
        if (out_end_position !== want.end_position)
          flag_mismatch("end_position", out_end_position, want.end_position);
        if (want.char_valid) n_chars++;
        else if (want.error_code == ERR_RANGE) n_range_err++;
        else if (want.error_code == ERR_JUMPS) n_jump_err++;
        else if (want.name_done) n_names++;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input int addr, input int data);
    dns_cmd_t c;
    c.op = op;
    c.addr = addr[8:0];
    c.data = data[7:0];
    cmd_q.push_back(c);
    pushed_count++;
  endtask

  // Waits until every queued transaction has been taken by the block.
  task automatic settle();
    while (accepted_count != pushed_count) @(negedge clk);
  endtask

  // Keeps one fetch in hand until the predicted walk has ended, then
  // sometimes adds a fetch against an idle walk.
  task automatic fetch_until_done();
    settle();
    while (walking) begin
      push_cmd(OP_FETCH, $urandom_range(0, 511), $urandom_range(0, 255));
      settle();
    end
    if ($urandom_range(0, 5) == 0) push_cmd(OP_FETCH, 0, 0);
  endtask

  task automatic walk_from(input int at);
    push_cmd(OP_START, at, $urandom_range(0, 255));
    fetch_until_done();
  endtask

  // Writes one encoded name at base without passing room_end: a few labels,
  // then a terminator, a pointer or a broken tail.
  task automatic build_name(input int base, input int room_end, output int tail_pos);
    int pos;
    int nlab;
    int len;
    int sel;
    int target;
    pos = base;
    nlab = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < nlab; i++) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
      if (pos + 1 + len + 2 > room_end) break;
      push_cmd(OP_WRITE, pos, len);
      for (int k = 1; k <= len; k++) push_cmd(OP_WRITE, pos + k, $urandom_range(0, 255));
      pos += 1 + len;
    end
    sel = (name_starts.size() == 0) ? 0 : $urandom_range(0, 19);
    if (sel < 10) begin
      push_cmd(OP_WRITE, pos, 0);
      pos += 1;
    end else if (sel < 18) begin
      if (sel < 16) target = name_starts[$urandom_range(0, name_starts.size() - 1)];
      else if (sel == 16) target = base;                  // pointer loop
      else target = $urandom_range(BUF_BYTES, 16383);     // target past the packet
      push_cmd(OP_WRITE, pos, PTR_MARK | target[13:8]);
      push_cmd(OP_WRITE, pos + 1, target[7:0]);
      pos += 2;
    end else if (sel == 18) begin
      push_cmd(OP_WRITE, pos, $urandom_range(8'h40, 8'hbf)); // reserved label type
      pos += 1;
    end else begin
      push_cmd(OP_WRITE, pos, $urandom_range(0, 255));
      pos += 1;
    end
    tail_pos = pos;
  endtask

  // Every byte is written before any walk, so no fetch reads unwritten memory.
  task automatic fill_packet();
    int pos;
    int nxt;
    pos = 0;
    while (pos < 440) begin
      build_name(pos, 460, nxt);
      name_starts.push_back(pos);
      pos = nxt;
    end
    for (int a = pos; a < BUF_BYTES; a++) push_cmd(OP_WRITE, a, 0);
  endtask

  task automatic directed_cases();
    // Extreme characters, a dot, then a pointer onto a zero byte at 494.
    push_cmd(OP_WRITE, 470, 1);
    push_cmd(OP_WRITE, 471, 8'hff);
    push_cmd(OP_WRITE, 472, 2);
    push_cmd(OP_WRITE, 473, 8'h00);
    push_cmd(OP_WRITE, 474, 8'h80);
    push_cmd(OP_WRITE, 475, PTR_MARK | 8'h01);
    push_cmd(OP_WRITE, 476, 8'hee);
    push_cmd(OP_START, 470, 0);
    push_cmd(OP_FETCH, 0, 0);
    walk_from(470);                        // restart after one character
    // A label that ends on the last byte leaves the walk past the packet.
    push_cmd(OP_WRITE, 509, 2);
    walk_from(509);
    // A label longer than the bytes left.
    push_cmd(OP_WRITE, 505, 63);
    walk_from(505);
    // A pointer to itself runs into the jump limit.
    push_cmd(OP_WRITE, 500, PTR_MARK | 8'h01);
    push_cmd(OP_WRITE, 501, 8'hf4);
    walk_from(500);
    // A pointer whose second byte would lie past the packet.
    push_cmd(OP_WRITE, 511, PTR_MARK);
    walk_from(511);
    push_cmd(OP_UNUSED, 511, 8'hff);
    push_cmd(OP_FETCH, 0, 0);
  endtask

  task automatic random_names(input int n_items);
    int stop_at;
    int sel;
    int base;
    int nxt;
    stop_at = pushed_count + n_items;
    while (pushed_count < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        base = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 510);
        build_name(base, BUF_BYTES, nxt);
        name_starts.push_back(base);
        if (name_starts.size() > 64) void'(name_starts.pop_front());
        walk_from(base);
      end else if (sel < 75) begin
        walk_from(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      end else if (sel < 85) begin
        walk_from($urandom_range(0, 511));
      end else if (sel < 92) begin
        // Abandon a walk part way and start another.
        push_cmd(OP_START, name_starts[$urandom_range(0, name_starts.size() - 1)], 0);
        repeat ($urandom_range(1, 3)) push_cmd(OP_FETCH, 0, 0);
        walk_from(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      end else if (sel < 96) begin
        // Rewrite a byte while a walk is running.
        push_cmd(OP_START, name_starts[$urandom_range(0, name_starts.size() - 1)], 0);
        push_cmd(OP_FETCH, 0, 0);
        push_cmd(OP_WRITE, $urandom_range(0, 511), $urandom_range(0, 255));
        fetch_until_done();
      end else begin
        push_cmd($urandom_range(0, 1) ? OP_UNUSED : OP_FETCH,
                 $urandom_range(0, 511), $urandom_range(0, 255));
      end
    end
  endtask

  // Waits until every transaction is taken and answered, plus a short tail.
  task automatic drain();
    while (accepted_count != pushed_count || name_results_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_jump_limit(input logic [3:0] lim);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= lim;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  logic [3:0] phase_limits [6] = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd15, 4'd5};

  initial begin
    logic [3:0] lim;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    fill_packet();
    directed_cases();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      lim = (ph == 3) ? 4'($urandom_range(2, 14)) : phase_limits[ph];
      set_jump_limit(lim);
      @(negedge clk);
      random_names(50);
      drain();
    end
    $display("covered %0d transactions: %0d characters, %0d names ended cleanly,",
             accepted_count, n_chars, n_names);
    $display("%0d range errors and %0d jump limit errors over six jump limits",
             n_range_err, n_jump_err);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/dnsd_pkg.sv
rtl/core/dnsd_packet_ram.sv
rtl/core/dns_name_decompressor.sv
dv/tb_top.sv
